[hw/rtl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the polyline shortcut compare block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  // default internal coordinate width (Q8.8)
  localparam int COORD_WIDTH_DEF = 16;
  // width of a coordinate field on the port
  localparam int PT_WIDTH        = 16;
  // width of a length (Q24.8)
  localparam int LEN_WIDTH       = 32;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic signed [PT_WIDTH-1:0] point_x;
    logic signed [PT_WIDTH-1:0] point_y;
    logic                       line_id;
    logic                       has_point;
    logic                       last_in_line;
  } point_t;

  typedef struct packed {
    logic                 is_shortcut;
    logic [LEN_WIDTH-1:0] length_a;
    logic [LEN_WIDTH-1:0] length_b;
  } result_t;

endpackage

[hw/rtl/polyline_shortcut_compare_top.sv]
// ----------------------------------------------------------------------------
// polyline_shortcut_compare_top
// Streams the points of line A then line B, sums both lengths and reports
// whether B is a shorter path between the same endpoints as A.
// ----------------------------------------------------------------------------
// A point beat that opens a new segment stalls the port while the segment
// unit runs: the shared multiplier squares dx and dy in turn and the square
// root then resolves one result bit per cycle. A beat that opens no segment
// (first point of a line, empty marker, last marker of A) is taken without
// a stall. The last beat of B then waits in the result state to load the
// result register; the next point beat is taken while an earlier result
// beat still waits downstream, unless a second result is ready first.
`timescale 1ns / 1ps

module polyline_shortcut_compare_top #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_stall,
  input  psc_pkg::point_t   point,
  output logic              result_valid,
  input  logic              result_stall,
  output psc_pkg::result_t  result
);
  import psc_pkg::*;

  localparam int CW = COORD_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEG    = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]              state;
  logic signed [CW-1:0]    a_first_x;
  logic signed [CW-1:0]    a_first_y;
  logic signed [CW-1:0]    a_last_x;
  logic signed [CW-1:0]    a_last_y;
  logic [LEN_WIDTH-1:0]    a_total;
  logic                    a_nonempty;
  logic signed [CW-1:0]    b_prev_x;
  logic signed [CW-1:0]    b_prev_y;
  logic [LEN_WIDTH-1:0]    b_total;
  logic                    b_started;
  logic                    b_start_matches;
  logic                    seg_to_b;
  logic                    last_pend;

  logic signed [CW-1:0]    px;
  logic signed [CW-1:0]    py;
  logic                    take;
  logic                    seg_start;
  logic                    seg_done;
  logic [LEN_WIDTH-1:0]    seg_len;
  logic [LEN_WIDTH:0]      acc_sum;
  logic [LEN_WIDTH-1:0]    acc_sat;
  logic                    res_load;

  // truncate or sign-extend the port coordinate to the working width
  assign px = CW'(point.point_x);
  assign py = CW'(point.point_y);

  assign point_stall = (state != ST_IDLE);
  assign take        = point_valid && (state == ST_IDLE);
  assign seg_start   = take && point.has_point &&
                       (point.line_id ? b_started : a_nonempty);
  assign res_load    = (state == ST_RESULT) && (!result_valid || !result_stall);

  psc_seglen #(
    .COORD_WIDTH (CW)
  ) u_seglen (
    .clk   (clk),
    .rst   (rst),
    .start (seg_start),
    .x1    (point.line_id ? b_prev_x : a_last_x),
    .y1    (point.line_id ? b_prev_y : a_last_y),
    .x2    (px),
    .y2    (py),
    .done  (seg_done),
    .len   (seg_len)
  );

  assign acc_sum = {1'b0, (seg_to_b ? b_total : a_total)} + {1'b0, seg_len};
  assign acc_sat = acc_sum[LEN_WIDTH] ? LEN_MAX : acc_sum[LEN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      result_valid    <= 1'b0;
      a_first_x       <= '0;
      a_first_y       <= '0;
      a_last_x        <= '0;
      a_last_y        <= '0;
      a_total         <= '0;
      a_nonempty      <= 1'b0;
      b_prev_x        <= '0;
      b_prev_y        <= '0;
      b_total         <= '0;
      b_started       <= 1'b0;
      b_start_matches <= 1'b0;
      seg_to_b        <= 1'b0;
      last_pend       <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            seg_to_b  <= point.line_id;
            last_pend <= point.line_id && point.last_in_line;
            if (seg_start) state <= ST_SEG;
            if (!point.line_id) begin
              if (point.has_point) begin
                if (!a_nonempty) begin
                  a_first_x  <= px;
                  a_first_y  <= py;
                  a_nonempty <= 1'b1;
                end
                a_last_x <= px;
                a_last_y <= py;
              end
            end else begin
              if (point.has_point) begin
                if (!b_started) begin
                  b_start_matches <= a_nonempty && px == a_first_x && py == a_first_y;
                  b_started       <= 1'b1;
                end
                b_prev_x <= px;
                b_prev_y <= py;
              end
              if (!seg_start && point.last_in_line) state <= ST_RESULT;
            end
          end
        end
        ST_SEG: begin
          if (seg_done) begin
            if (seg_to_b) b_total <= acc_sat;
            else          a_total <= acc_sat;
            state <= last_pend ? ST_RESULT : ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (res_load) begin
            a_first_x       <= '0;
            a_first_y       <= '0;
            a_last_x        <= '0;
            a_last_y        <= '0;
            a_total         <= '0;
            a_nonempty      <= 1'b0;
            b_prev_x        <= '0;
            b_prev_y        <= '0;
            b_total         <= '0;
            b_started       <= 1'b0;
            b_start_matches <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.is_shortcut <= a_nonempty && b_started && b_start_matches &&
                            b_prev_x == a_last_x && b_prev_y == a_last_y &&
                            b_total < a_total;
      result.length_a    <= a_total;
      result.length_b    <= b_total;
    end
  end

endmodule

[hw/rtl/psc_isqrt.sv]
// ----------------------------------------------------------------------------
// psc_isqrt
// Iterative integer square root, truncating. Two radicand bits per cycle,
// one compare and subtract per step, W steps for a 2*W bit radicand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_isqrt #(
  parameter int W = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);
  import psc_pkg::*;

  localparam int RW   = W + 3;
  localparam int CNTW = $clog2(W);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [2*W-1:0]  rad;
  logic [RW-1:0]   rem;
  logic [W-1:0]    root_r;

  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   trial;
  logic [RW-1:0]   rem_next;
  logic [W-1:0]    root_next;

  always_comb begin
    rem_sh = {rem[RW-3:0], rad[2*W-1:2*W-2]};
    trial  = RW'({root_r, 2'b01});
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root_r[W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == CNTW'(W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= radicand;
      rem    <= '0;
      root_r <= '0;
    end else if (run) begin
      rad    <= {rad[2*W-3:0], 2'b00};
      rem    <= rem_next;
      root_r <= root_next;
    end
  end

  assign root = root_r;

endmodule

[hw/rtl/psc_seglen.sv]
// ----------------------------------------------------------------------------
// psc_seglen
// Segment length: absolute differences, squares on one shared multiplier,
// then the iterative square root, saturated to the length width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_seglen #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_WIDTH-1:0]  x1,
  input  logic signed [COORD_WIDTH-1:0]  y1,
  input  logic signed [COORD_WIDTH-1:0]  x2,
  input  logic signed [COORD_WIDTH-1:0]  y2,
  output logic                           done,
  output logic [psc_pkg::LEN_WIDTH-1:0]  len
);
  import psc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int RTW = CW + 1;

  localparam logic [2:0] SL_IDLE = 3'd0;
  localparam logic [2:0] SL_MX   = 3'd1;
  localparam logic [2:0] SL_MY   = 3'd2;
  localparam logic [2:0] SL_ADD  = 3'd3;
  localparam logic [2:0] SL_ROOT = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       dx;
  logic [CW-1:0]       dy;
  logic [2*CW-1:0]     prod;
  logic [2*CW-1:0]     sqx;

  logic signed [CW:0]  ddx;
  logic signed [CW:0]  ddy;
  logic [CW:0]         ndx;
  logic [CW:0]         ndy;
  logic [CW-1:0]       mul_op;
  logic                sq_start;
  logic [2*RTW-1:0]    radicand;
  logic                sq_done;
  logic [RTW-1:0]      root;
  logic [63:0]         root_ext;

  assign ddx = {x1[CW-1], x1} - {x2[CW-1], x2};
  assign ddy = {y1[CW-1], y1} - {y2[CW-1], y2};
  assign ndx = -ddx;
  assign ndy = -ddy;

  assign mul_op   = (state == SL_MX) ? dx : dy;
  assign sq_start = (state == SL_ADD);
  assign radicand = (2*RTW)'(sqx) + (2*RTW)'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SL_IDLE;
    end else begin
      case (state)
        SL_IDLE: if (start) state <= SL_MX;
        SL_MX:   state <= SL_MY;
        SL_MY:   state <= SL_ADD;
        SL_ADD:  state <= SL_ROOT;
        SL_ROOT: if (sq_done) state <= SL_IDLE;
        default: state <= SL_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == SL_IDLE) begin
      dx <= ddx[CW] ? ndx[CW-1:0] : ddx[CW-1:0];
      dy <= ddy[CW] ? ndy[CW-1:0] : ddy[CW-1:0];
    end
    if (state == SL_MX || state == SL_MY) begin
      prod <= (2*CW)'(mul_op) * (2*CW)'(mul_op);
    end
    if (state == SL_MY) begin
      sqx <= prod;
    end
  end

  psc_isqrt #(
    .W (RTW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  // root can pass the length range only at the widest coordinates
  assign root_ext = 64'(root);
  assign len  = (|root_ext[63:LEN_WIDTH]) ? LEN_MAX : root_ext[LEN_WIDTH-1:0];
  assign done = sq_done && (state == SL_ROOT);

endmodule
